// ===== sv/lpc_pkg.sv =====
// Shared constants, codes and control types of the layer pixel compositor.
// Used by the controller, the datapath and the top level; depends on nothing.
package lpc_pkg;

  localparam int DISPLAY_WIDTH  = 320;
  localparam int DISPLAY_HEIGHT = 240;
  localparam int FRAME_DEPTH    = DISPLAY_WIDTH * DISPLAY_HEIGHT;
  localparam int ADDR_W         = $clog2(FRAME_DEPTH);

  localparam int COORD_W    = 12;
  localparam int DISP_W     = 10;
  localparam int CH_W       = 8;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int OPAC_W     = 9;

  localparam logic [OPAC_W-1:0] OPACITY_FULL = OPAC_W'(256);
  localparam logic [CH_W-1:0]   CH_MAX       = CH_W'(255);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MIN_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MIN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MAX_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MAX_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN     = 3'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_COMPOSE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  // Step strobes from the controller to the datapath
  typedef struct packed {
    logic load;
    logic map;
    logic fetch;
    logic blend;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== sv/lpc_ctrl.sv =====
// Sequencer of the compositor: steps one word through map, fetch, blend and
// write, and owns the input ready and output valid. Depends on lpc_pkg.
module lpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpc_pkg::ctrl_cmd_t cmd_o
);
  import lpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_FETCH,
    S_BLEND,
    S_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, commit;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  // hold the finished word until the output register is free
  assign commit = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_MAP;
      S_MAP:   state_d = S_FETCH;
      S_FETCH: state_d = S_BLEND;
      S_BLEND: state_d = S_WRITE;
      S_WRITE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    out_valid_d = commit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.map    = (state_q == S_MAP);
  assign cmd_o.fetch  = (state_q == S_FETCH);
  assign cmd_o.blend  = (state_q == S_BLEND);
  assign cmd_o.commit = commit;

endmodule

// ===== sv/lpc_datapath.sv =====
// Datapath of the compositor: layer registers, coordinate mapping, alpha
// scaling, the frame store and the blend. Depends on lpc_pkg.
module lpc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lpc_pkg::ctrl_cmd_t             cmd_i,
  input  logic                           cfg_we_i,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [lpc_pkg::CMD_W-1:0]      in_cmd_i,
  input  logic [lpc_pkg::COORD_W-1:0]    in_coord_x_i,
  input  logic [lpc_pkg::COORD_W-1:0]    in_coord_y_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_red_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_green_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_blue_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_alpha_i,
  output logic                           out_wrote_o,
  output logic [lpc_pkg::DISP_W-1:0]     out_disp_x_o,
  output logic [lpc_pkg::DISP_W-1:0]     out_disp_y_o,
  output logic [lpc_pkg::CH_W-1:0]       out_red_o,
  output logic [lpc_pkg::CH_W-1:0]       out_green_o,
  output logic [lpc_pkg::CH_W-1:0]       out_blue_o
);
  import lpc_pkg::*;

  localparam int DX_W  = COORD_W + 2;
  localparam int PIX_W = 3 * CH_W;

  typedef enum logic [2:0] {
    MODE_DROP,
    MODE_COPY,
    MODE_BLEND,
    MODE_READ,
    MODE_CLEAR
  } mode_e;

  function automatic logic [2*CH_W-1:0] mix(input logic [CH_W-1:0] s,
                                            input logic [CH_W-1:0] d,
                                            input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] ps, pd;
    ps = (2*CH_W)'(s) * (2*CH_W)'(a);
    pd = (2*CH_W)'(d) * (2*CH_W)'(CH_MAX - a);
    return ps + pd;
  endfunction

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] t;
    t = {1'b0, x} + (2*CH_W+1)'(x[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return t[2*CH_W-1:CH_W];
  endfunction

  // layer registers
  logic [COORD_W-1:0]   pos_x_q, pos_y_q, vmin_x_q, vmin_y_q;
  logic [COORD_W:0]     vmax_x_q, vmax_y_q;
  logic [OPAC_W-1:0]    opacity_q;
  logic                 hidden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      vmin_x_q  <= '0;
      vmin_y_q  <= '0;
      vmax_x_q  <= (COORD_W+1)'(4096);
      vmax_y_q  <= (COORD_W+1)'(4096);
      opacity_q <= OPACITY_FULL;
      hidden_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POS_X:      pos_x_q   <= cfg_data_i[COORD_W-1:0];
        REG_POS_Y:      pos_y_q   <= cfg_data_i[COORD_W-1:0];
        REG_VIEW_MIN_X: vmin_x_q  <= cfg_data_i[COORD_W-1:0];
        REG_VIEW_MIN_Y: vmin_y_q  <= cfg_data_i[COORD_W-1:0];
        REG_VIEW_MAX_X: vmax_x_q  <= cfg_data_i[COORD_W:0];
        REG_VIEW_MAX_Y: vmax_y_q  <= cfg_data_i[COORD_W:0];
        REG_OPACITY:    opacity_q <= cfg_data_i[OPAC_W-1:0];
        REG_HIDDEN:     hidden_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input word
  logic [CMD_W-1:0]   cmd_q;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic [CH_W-1:0]    sr_q, sg_q, sb_q, sa_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      cx_q  <= in_coord_x_i;
      cy_q  <= in_coord_y_i;
      sr_q  <= in_src_red_i;
      sg_q  <= in_src_green_i;
      sb_q  <= in_src_blue_i;
      sa_q  <= in_src_alpha_i;
    end
  end

  // map: display position, window and display checks, effective alpha
  logic [DX_W-1:0]     dx, dy;
  logic                in_view, on_disp, rc_on_disp;
  logic [OPAC_W-1:0]   op_sat;
  logic [CH_W+OPAC_W-1:0] a_full;
  logic [CH_W-1:0]     a_eff;
  logic [DISP_W-1:0]   px, py;
  logic [ADDR_W-1:0]   addr;
  mode_e               mode;

  always_comb begin
    dx = {2'b00, cx_q} + {{2{pos_x_q[COORD_W-1]}}, pos_x_q} - {2'b00, vmin_x_q};
    dy = {2'b00, cy_q} + {{2{pos_y_q[COORD_W-1]}}, pos_y_q} - {2'b00, vmin_y_q};
    in_view = (cx_q >= vmin_x_q) && ({1'b0, cx_q} < vmax_x_q)
           && (cy_q >= vmin_y_q) && ({1'b0, cy_q} < vmax_y_q);
    on_disp = !dx[DX_W-1] && !dy[DX_W-1]
           && (dx[DX_W-2:0] < (DX_W-1)'(DISPLAY_WIDTH))
           && (dy[DX_W-2:0] < (DX_W-1)'(DISPLAY_HEIGHT));
    rc_on_disp = (cx_q < COORD_W'(DISPLAY_WIDTH)) && (cy_q < COORD_W'(DISPLAY_HEIGHT));
    op_sat = (opacity_q > OPACITY_FULL) ? OPACITY_FULL : opacity_q;
    a_full = (CH_W+OPAC_W)'(sa_q) * (CH_W+OPAC_W)'(op_sat);
    a_eff  = a_full[CH_W+CH_W-1:CH_W];
    px = cx_q[DISP_W-1:0];
    py = cy_q[DISP_W-1:0];
    mode = MODE_DROP;
    unique case (cmd_q)
      CMD_COMPOSE: begin
        px = dx[DISP_W-1:0];
        py = dy[DISP_W-1:0];
        if (!hidden_q && in_view && (sa_q != '0) && on_disp) begin
          mode = (a_eff == CH_MAX) ? MODE_COPY : MODE_BLEND;
        end
      end
      CMD_READ:  if (rc_on_disp) mode = MODE_READ;
      CMD_CLEAR: if (rc_on_disp) mode = MODE_CLEAR;
      default:   mode = MODE_DROP;
    endcase
    addr = ADDR_W'(ADDR_W'(py) * ADDR_W'(DISPLAY_WIDTH)) + ADDR_W'(px);
  end

  mode_e             mode_q;
  logic [CH_W-1:0]   a_q;
  logic [DISP_W-1:0] px_q, py_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      mode_q <= mode;
      a_q    <= a_eff;
      px_q   <= px;
      py_q   <= py;
      addr_q <= addr;
    end
  end

  // frame store, single port, registered read
  logic [PIX_W-1:0] frame_mem [FRAME_DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] pix;
  logic             wrote;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      rd_q <= frame_mem[addr_q];
    end
    if (cmd_i.commit && wrote) begin
      frame_mem[addr_q] <= pix;
    end
  end

  // blend products
  logic [2*CH_W-1:0] prod_r_q, prod_g_q, prod_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.blend) begin
      prod_r_q <= mix(sr_q, rd_q[PIX_W-1:2*CH_W], a_q);
      prod_g_q <= mix(sg_q, rd_q[2*CH_W-1:CH_W], a_q);
      prod_b_q <= mix(sb_q, rd_q[CH_W-1:0], a_q);
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_COPY:  pix = {sr_q, sg_q, sb_q};
      MODE_BLEND: pix = {div255(prod_r_q), div255(prod_g_q), div255(prod_b_q)};
      MODE_READ:  pix = rd_q;
      default:    pix = '0;
    endcase
    wrote = (mode_q == MODE_COPY) || (mode_q == MODE_BLEND) || (mode_q == MODE_CLEAR);
  end

  // output register
  logic              wrote_q;
  logic [DISP_W-1:0] ox_q, oy_q;
  logic [PIX_W-1:0]  opix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      wrote_q <= wrote;
      ox_q    <= (mode_q == MODE_DROP) ? '0 : px_q;
      oy_q    <= (mode_q == MODE_DROP) ? '0 : py_q;
      opix_q  <= pix;
    end
  end

  assign out_wrote_o  = wrote_q;
  assign out_disp_x_o = ox_q;
  assign out_disp_y_o = oy_q;
  assign out_red_o    = opix_q[PIX_W-1:2*CH_W];
  assign out_green_o  = opix_q[2*CH_W-1:CH_W];
  assign out_blue_o   = opix_q[CH_W-1:0];

endmodule

// ===== sv/layer_pixel_compositor_unit.sv =====
// Top level of the layer pixel compositor: controller plus datapath.
// Depends on lpc_pkg, lpc_ctrl and lpc_datapath.
//
// Composites layer pixels into a 320 x 240 frame store of 24-bit RGB and also
// reads or clears single display pixels. After accept, a word passes map and
// alpha scaling, frame store read, blend multiply, then divide and write back,
// and its result is then registered on the output. The read-modify-write
// through the single-port frame store sets this sequence, so a word holds the
// block until it is written and no new word is taken before that. A new
// word is taken once the previous one is written, even while its result still
// waits in the output register. A word that reaches write back while a result
// still waits is held there until the output register is free.
// The frame store is not cleared at reset; write every pixel (clear or opaque
// compose) before it is read or blended over. Configuration writes take effect
// at once and belong in idle periods.
module layer_pixel_compositor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lpc_pkg::CMD_W-1:0]      in_cmd_i,
  input  logic [lpc_pkg::COORD_W-1:0]    in_coord_x_i,
  input  logic [lpc_pkg::COORD_W-1:0]    in_coord_y_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_red_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_green_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_blue_i,
  input  logic [lpc_pkg::CH_W-1:0]       in_src_alpha_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_wrote_o,
  output logic [lpc_pkg::DISP_W-1:0]     out_disp_x_o,
  output logic [lpc_pkg::DISP_W-1:0]     out_disp_y_o,
  output logic [lpc_pkg::CH_W-1:0]       out_red_o,
  output logic [lpc_pkg::CH_W-1:0]       out_green_o,
  output logic [lpc_pkg::CH_W-1:0]       out_blue_o
);
  import lpc_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  lpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (ctrl_cmd)
  );

  lpc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_cmd_i       (in_cmd_i),
    .in_coord_x_i   (in_coord_x_i),
    .in_coord_y_i   (in_coord_y_i),
    .in_src_red_i   (in_src_red_i),
    .in_src_green_i (in_src_green_i),
    .in_src_blue_i  (in_src_blue_i),
    .in_src_alpha_i (in_src_alpha_i),
    .out_wrote_o    (out_wrote_o),
    .out_disp_x_o   (out_disp_x_o),
    .out_disp_y_o   (out_disp_y_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o)
  );

endmodule

// ===== sv/lpc_checker.sv =====
// Port-level checks of the compositor, bound to the top level.
// Depends on lpc_pkg for the display size.
module lpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           out_wrote_o,
  input logic [lpc_pkg::DISP_W-1:0]     out_disp_x_o,
  input logic [lpc_pkg::DISP_W-1:0]     out_disp_y_o,
  input logic [lpc_pkg::CH_W-1:0]       out_red_o,
  input logic [lpc_pkg::CH_W-1:0]       out_green_o,
  input logic [lpc_pkg::CH_W-1:0]       out_blue_o
);
  import lpc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_wrote_o)
      && $stable(out_disp_x_o) && $stable(out_disp_y_o) && $stable(out_red_o)
      && $stable(out_green_o) && $stable(out_blue_o))
    else $error("stalled result changed");

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

  // ready returns only together with a fresh result
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("ready returned without a result");

  // addressed position always lies on the display
  a_disp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_disp_x_o < DISP_W'(DISPLAY_WIDTH))
      && (out_disp_y_o < DISP_W'(DISPLAY_HEIGHT)))
    else $error("display position off the display");

endmodule

bind layer_pixel_compositor_unit lpc_checker u_lpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_wrote_o  (out_wrote_o),
  .out_disp_x_o (out_disp_x_o),
  .out_disp_y_o (out_disp_y_o),
  .out_red_o    (out_red_o),
  .out_green_o  (out_green_o),
  .out_blue_o   (out_blue_o)
);
